/* src/pngu_pkg.sv */
// ----------------------------------------------------------------------------
// PNG unfilter package
// Shared constants, codes, structs and helper functions of the scanline
// unfilter and RGBA conversion block.
// ----------------------------------------------------------------------------
package pngu_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_CHANNELS = 4;
    localparam int ROW_BYTES    = MAX_WIDTH * MAX_CHANNELS;
    localparam int ROW_ADDR_W   = $clog2(ROW_BYTES);
    localparam int LEN_W        = ROW_ADDR_W + 1;
    localparam int TABLE_DEPTH  = 256;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // Item kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_ALPHA   = 2'd2;

    // Color types
    localparam logic [2:0] CT_GRAY       = 3'd0;
    localparam logic [2:0] CT_RGB        = 3'd2;
    localparam logic [2:0] CT_PALETTE    = 3'd3;
    localparam logic [2:0] CT_GRAY_ALPHA = 3'd4;
    localparam logic [2:0] CT_RGBA       = 3'd6;

    // Row filter codes
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_TYPE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_COUNT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_COUNT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_ENABLE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRAY_KEY      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_RGB_KEY       = 3'd7;

    typedef struct packed {
        logic [2:0]  color_type;
        logic [12:0] image_width;
        logic [15:0] image_height;
        logic [8:0]  palette_count;
        logic [8:0]  alpha_count;
        logic        key_enable;
        logic [7:0]  gray_key;
        logic [23:0] rgb_key;
    } cfg_t;

    // One finished pixel, or the error beat, on its way to color conversion.
    typedef struct packed {
        logic        err;
        logic [31:0] pix;
        logic [11:0] column;
        logic [15:0] line;
        logic        last;
    } pix_t;

    typedef struct packed {
        logic        pal_we;
        logic        alpha_we;
        logic [7:0]  index;
        logic [23:0] rgb;
        logic [7:0]  alpha;
    } tbl_wr_t;

    function automatic logic [2:0] channels_of(input logic [2:0] ct);
        logic [2:0] n;
        unique case (ct) inside
            CT_GRAY, CT_PALETTE: n = 3'd1;
            CT_RGB:              n = 3'd3;
            CT_GRAY_ALPHA:       n = 3'd2;
            default:             n = 3'd4;
        endcase
        return n;
    endfunction

    // Paeth predictor: pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|.
    function automatic logic [7:0] paeth_select(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
        logic signed [9:0] db;
        logic signed [9:0] da;
        logic signed [9:0] ds;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        logic [7:0]        res;
        db = signed'({2'b00, b}) - signed'({2'b00, c});
        da = signed'({2'b00, a}) - signed'({2'b00, c});
        ds = db + da;
        pa = (db < 0) ? 10'(-db) : 10'(db);
        pb = (da < 0) ? 10'(-da) : 10'(da);
        pc = (ds < 0) ? 10'(-ds) : 10'(ds);
        if (pa <= pb && pa <= pc)
            res = a;
        else if (pb <= pc)
            res = b;
        else
            res = c;
        return res;
    endfunction

endpackage

/* src/pngu_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pngu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/pngu_config.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the image format, table counts and color keys written by the
// configuration port.
// ----------------------------------------------------------------------------
module pngu_config
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pngu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pngu_pkg::cfg_t                     cfg
);
    import pngu_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COLOR_TYPE:    cfg_next.color_type    = cfg_data[2:0];
                CFG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[12:0];
                CFG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[15:0];
                CFG_PALETTE_COUNT: cfg_next.palette_count = cfg_data[8:0];
                CFG_ALPHA_COUNT:   cfg_next.alpha_count   = cfg_data[8:0];
                CFG_KEY_ENABLE:    cfg_next.key_enable    = cfg_data[0];
                CFG_GRAY_KEY:      cfg_next.gray_key      = cfg_data[7:0];
                CFG_RGB_KEY:       cfg_next.rgb_key       = cfg_data[23:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_type    <= CT_RGBA;
            cfg_reg.image_width   <= 13'd1;
            cfg_reg.image_height  <= 16'd1;
            cfg_reg.palette_count <= '0;
            cfg_reg.alpha_count   <= '0;
            cfg_reg.key_enable    <= 1'b0;
            cfg_reg.gray_key      <= '0;
            cfg_reg.rgb_key       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

/* src/pngu_unfilter.sv */
// ----------------------------------------------------------------------------
// Scanline unfilter stage
// Undoes the row filter of each accepted data byte against the left pixel and
// the previous-row buffer, assembles pixels and registers each finished one.
// ----------------------------------------------------------------------------
module pngu_unfilter
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pngu_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic [7:0]           value,
    output logic                 mid_valid,
    input  logic                 mid_ready,
    output pngu_pkg::pix_t       mid,
    output logic                 tbl_rd_en,
    output logic [7:0]           tbl_rd_addr
);
    import pngu_pkg::*;

    localparam int DIV3_SHIFT  = ROW_ADDR_W + 2;
    localparam int DIV3_MULT   = (2 ** DIV3_SHIFT) / 3 + 1;
    localparam int DIV_PROD_W  = ROW_ADDR_W + DIV3_SHIFT;

    logic [ROW_ADDR_W-1:0] byte_col_reg;
    logic [ROW_ADDR_W-1:0] byte_col_next;
    logic [LEN_W-1:0]      extent_reg;
    logic [LEN_W-1:0]      extent_next;
    logic [15:0]           row_cnt_reg;
    logic [15:0]           row_cnt_next;
    logic [2:0]            filt_reg;
    logic [2:0]            filt_next;
    logic                  awaiting_reg;
    logic                  awaiting_next;
    logic                  halted_reg;
    logic                  halted_next;
    logic [31:0]           left_reg;
    logic [31:0]           left_next;
    logic [31:0]           ul_reg;
    logic [31:0]           ul_next;
    logic [23:0]           pixb_reg;
    logic [23:0]           pixb_next;
    logic                  mid_valid_reg;
    logic                  mid_valid_next;
    pix_t                  mid_reg;
    pix_t                  mid_next;

    logic                  data_fire;
    logic                  filt_beat;
    logic                  byte_beat;
    logic                  mid_load;
    logic [2:0]            bpp;
    logic [LEN_W-1:0]      w_eff;
    logic [LEN_W-1:0]      line_len;
    logic [DIV_PROD_W-1:0] div3_prod;
    logic [ROW_ADDR_W-1:0] q3;
    logic [LEN_W-1:0]      rem3;
    logic [ROW_ADDR_W-1:0] q;
    logic [1:0]            c;
    logic [7:0]            row_rdata;
    logic [7:0]            b_row;
    logic [7:0]            a_left;
    logic [7:0]            ul_byte;
    logic [8:0]            avg_sum;
    logic [7:0]            pred;
    logic [7:0]            x;
    logic [LEN_W-1:0]      next_col;
    logic                  row_end;
    logic                  last_chan;
    logic [31:0]           pix_word;
    logic [31:0]           ul_word;

    assign in_ready  = !mid_valid_reg || mid_ready;
    assign data_fire = in_valid && in_ready && (kind == KIND_DATA) && !halted_reg
                       && (row_cnt_reg < cfg.image_height);
    assign filt_beat = data_fire && awaiting_reg;
    assign byte_beat = data_fire && !awaiting_reg;

    // Row geometry and position of the current byte within its pixel.
    always_comb
    begin
        bpp = channels_of(cfg.color_type);
        if (cfg.image_width == '0)
            w_eff = LEN_W'(1);
        else if (int'(cfg.image_width) > MAX_WIDTH)
            w_eff = LEN_W'(MAX_WIDTH);
        else
            w_eff = LEN_W'(cfg.image_width);

        // Division by three through a reciprocal, exact over the row range.
        div3_prod = DIV_PROD_W'(byte_col_reg) * DIV_PROD_W'(DIV3_MULT);
        q3        = div3_prod[DIV3_SHIFT +: ROW_ADDR_W];
        rem3      = {1'b0, byte_col_reg} - {1'b0, q3} - {q3, 1'b0};

        case (bpp)
            3'd1:
            begin
                line_len = w_eff;
                q        = byte_col_reg;
                c        = 2'd0;
            end
            3'd2:
            begin
                line_len = w_eff << 1;
                q        = byte_col_reg >> 1;
                c        = {1'b0, byte_col_reg[0]};
            end
            3'd3:
            begin
                line_len = w_eff + (w_eff << 1);
                q        = q3;
                c        = rem3[1:0];
            end
            default:
            begin
                line_len = w_eff << 2;
                q        = byte_col_reg >> 2;
                c        = byte_col_reg[1:0];
            end
        endcase
    end

    // Unfilter of one byte.
    always_comb
    begin
        b_row    = ({1'b0, byte_col_reg} < extent_reg) ? row_rdata : 8'h00;
        a_left   = left_reg[{c, 3'b000} +: 8];
        ul_byte  = ul_reg[{c, 3'b000} +: 8];
        avg_sum  = {1'b0, a_left} + {1'b0, b_row};
        case (filt_reg)
            FILT_SUB:   pred = a_left;
            FILT_UP:    pred = b_row;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth_select(a_left, b_row, ul_byte);
            default:    pred = 8'h00;
        endcase
        x         = value + pred;
        next_col  = {1'b0, byte_col_reg} + LEN_W'(1);
        row_end   = next_col >= line_len;
        last_chan = ({1'b0, c} + 3'd1) == bpp;
        // The new byte is merged in, so a byte left over from a wider pixel
        // format survives a mid-row change of color type.
        pix_word  = (c == 2'd0) ? 32'h0 : {8'h00, pixb_reg};
        pix_word  = pix_word | ({24'h000000, x} << {c, 3'b000});
        ul_word   = ul_reg;
        ul_word[{c, 3'b000} +: 8] = b_row;
    end

    // Next-state logic.
    always_comb
    begin
        byte_col_next  = byte_col_reg;
        extent_next    = extent_reg;
        row_cnt_next   = row_cnt_reg;
        filt_next      = filt_reg;
        awaiting_next  = awaiting_reg;
        halted_next    = halted_reg;
        left_next      = left_reg;
        ul_next        = ul_reg;
        pixb_next      = pixb_reg;
        mid_next       = mid_reg;
        mid_load       = 1'b0;

        if (filt_beat)
        begin
            if (value > {5'd0, FILT_PAETH})
            begin
                halted_next     = 1'b1;
                mid_load        = 1'b1;
                mid_next.err    = 1'b1;
                mid_next.pix    = '0;
                mid_next.column = '0;
                mid_next.line   = row_cnt_reg;
                mid_next.last   = 1'b0;
            end
            else
            begin
                filt_next     = value[2:0];
                awaiting_next = 1'b0;
                byte_col_next = '0;
                left_next     = '0;
                ul_next       = '0;
                pixb_next     = '0;
            end
        end
        else if (byte_beat)
        begin
            ul_next = ul_word;
            // The row buffer has been written below this mark since reset.
            if (next_col > extent_reg)
            begin
                extent_next = next_col;
            end
            if (row_end)
            begin
                awaiting_next = 1'b1;
                row_cnt_next  = row_cnt_reg + 16'd1;
                byte_col_next = '0;
            end
            else
            begin
                byte_col_next = ROW_ADDR_W'(next_col);
            end
            if (last_chan)
            begin
                left_next       = pix_word;
                pixb_next       = '0;
                mid_load        = 1'b1;
                mid_next.err    = 1'b0;
                mid_next.pix    = pix_word;
                mid_next.column = 12'(q);
                mid_next.line   = row_cnt_reg;
                mid_next.last   = row_end
                                  && (({1'b0, row_cnt_reg} + 17'd1) == {1'b0, cfg.image_height});
            end
            else
            begin
                pixb_next = pix_word[23:0];
            end
        end

        if (mid_load)
            mid_valid_next = 1'b1;
        else if (mid_ready)
            mid_valid_next = 1'b0;
        else
            mid_valid_next = mid_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_col_reg  <= '0;
            extent_reg    <= '0;
            row_cnt_reg   <= '0;
            filt_reg      <= FILT_NONE;
            awaiting_reg  <= 1'b1;
            halted_reg    <= 1'b0;
            left_reg      <= '0;
            ul_reg        <= '0;
            pixb_reg      <= '0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            byte_col_reg  <= byte_col_next;
            extent_reg    <= extent_next;
            row_cnt_reg   <= row_cnt_next;
            filt_reg      <= filt_next;
            awaiting_reg  <= awaiting_next;
            halted_reg    <= halted_next;
            left_reg      <= left_next;
            ul_reg        <= ul_next;
            pixb_reg      <= pixb_next;
            mid_valid_reg <= mid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
    end

    // The read address runs one byte ahead, so the stored byte above the
    // next data byte is already registered when that byte arrives.
    pngu_ram #(
        .WIDTH (8),
        .DEPTH (ROW_BYTES)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (byte_beat),
        .wr_addr (byte_col_reg),
        .wr_data (x),
        .rd_en   (1'b1),
        .rd_addr (byte_col_next),
        .rd_data (row_rdata)
    );

    assign mid_valid   = mid_valid_reg;
    assign mid         = mid_reg;
    assign tbl_rd_en   = mid_load;
    assign tbl_rd_addr = pix_word[7:0];

    property p_halt_sticky;
        @(posedge clk) disable iff (!rst_n) halted_reg |=> halted_reg;
    endproperty
    a_halt_sticky: assert property (p_halt_sticky)
        else $error("decoder left the halted state without reset");

    property p_error_halts;
        @(posedge clk) disable iff (!rst_n) (mid_load && filt_beat) |=> halted_reg;
    endproperty
    a_error_halts: assert property (p_error_halts)
        else $error("error beat issued without halting");

    property p_extent_grows;
        @(posedge clk) disable iff (!rst_n) 1'b1 |=> (extent_reg >= $past(extent_reg));
    endproperty
    a_extent_grows: assert property (p_extent_grows)
        else $error("row buffer fill mark moved backward");

    property p_row_start;
        @(posedge clk) disable iff (!rst_n) awaiting_reg |-> (byte_col_reg == '0);
    endproperty
    a_row_start: assert property (p_row_start)
        else $error("byte column not at row start while waiting for a filter byte");

endmodule

/* src/pngu_color.sv */
// ----------------------------------------------------------------------------
// Color conversion stage
// Turns a finished pixel into red, green, blue and alpha, holds the palette
// and per-index alpha tables and drives the output register.
// ----------------------------------------------------------------------------
module pngu_color
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pngu_pkg::cfg_t       cfg,
    input  logic                 mid_valid,
    output logic                 mid_ready,
    input  pngu_pkg::pix_t       mid,
    input  pngu_pkg::tbl_wr_t    tbl_wr,
    input  logic                 tbl_rd_en,
    input  logic [7:0]           tbl_rd_addr,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue,
    output logic [7:0]           alpha,
    output logic [11:0]          column,
    output logic [15:0]          line_number,
    output logic                 last_of_image,
    output logic                 filter_error
);
    import pngu_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;
    logic [11:0] column_reg;
    logic [15:0] line_reg;
    logic        last_reg;
    logic        err_reg;

    logic        advance;
    logic [23:0] pal_rdata;
    logic [7:0]  alpha_rdata;
    logic [7:0]  p0;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [7:0]  p3;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  bl;
    logic [7:0]  al;

    // Table reads are issued when the pixel enters the stage before this one.
    pngu_ram #(
        .WIDTH (24),
        .DEPTH (TABLE_DEPTH)
    ) u_palette_ram (
        .clk     (clk),
        .wr_en   (tbl_wr.pal_we),
        .wr_addr (tbl_wr.index),
        .wr_data (tbl_wr.rgb),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (pal_rdata)
    );

    pngu_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_alpha_ram (
        .clk     (clk),
        .wr_en   (tbl_wr.alpha_we),
        .wr_addr (tbl_wr.index),
        .wr_data (tbl_wr.alpha),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (alpha_rdata)
    );

    assign mid_ready = !out_valid_reg || out_ready;
    assign advance   = mid_valid && mid_ready;

    always_comb
    begin
        p0 = mid.pix[7:0];
        p1 = mid.pix[15:8];
        p2 = mid.pix[23:16];
        p3 = mid.pix[31:24];
        r  = p0;
        g  = p1;
        bl = p2;
        al = p3;
        if (mid.err)
        begin
            r  = 8'h00;
            g  = 8'h00;
            bl = 8'h00;
            al = 8'h00;
        end
        else
        begin
            case (cfg.color_type)
                CT_GRAY:
                begin
                    g  = p0;
                    bl = p0;
                    al = (cfg.key_enable && p0 == cfg.gray_key) ? 8'h00 : ALPHA_OPAQUE;
                end
                CT_RGB:
                begin
                    al = (cfg.key_enable && {p0, p1, p2} == cfg.rgb_key) ? 8'h00
                                                                         : ALPHA_OPAQUE;
                end
                CT_PALETTE:
                begin
                    // Indexes past the palette give black.
                    if ({1'b0, p0} < cfg.palette_count)
                    begin
                        r  = pal_rdata[23:16];
                        g  = pal_rdata[15:8];
                        bl = pal_rdata[7:0];
                    end
                    else
                    begin
                        r  = 8'h00;
                        g  = 8'h00;
                        bl = 8'h00;
                    end
                    al = ({1'b0, p0} < cfg.alpha_count) ? alpha_rdata : ALPHA_OPAQUE;
                end
                CT_GRAY_ALPHA:
                begin
                    g  = p0;
                    bl = p0;
                    al = p1;
                end
                default:
                begin
                    r  = p0;
                    g  = p1;
                    bl = p2;
                    al = p3;
                end
            endcase
        end

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg    <= r;
            green_reg  <= g;
            blue_reg   <= bl;
            alpha_reg  <= al;
            column_reg <= mid.column;
            line_reg   <= mid.line;
            last_reg   <= mid.last;
            err_reg    <= mid.err;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign alpha         = alpha_reg;
    assign column        = column_reg;
    assign line_number   = line_reg;
    assign last_of_image = last_reg;
    assign filter_error  = err_reg;

endmodule

/* src/png_scanline_unfilter_to_rgba_core.sv */
// ----------------------------------------------------------------------------
// PNG scanline unfilter to RGBA
// Top level: configuration registers, unfilter stage and color stage.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while in_ready is high and
// presents each finished pixel through the unfilter stage's pixel register
// and then an output register, so a stalled output does not stop input
// until both internal stages are full.
// The rate is one byte per cycle when unstalled, set by the unfilter step,
// which needs the left pixel of the byte just before and a previous-row byte
// that the row buffer (16384 x 8, one write and one read port) reads one byte
// ahead. The row buffer needs no clearing pass after reset: a fill mark makes
// bytes never written since reset read as zero. Palette and alpha entries are
// loaded with data beats of their own kind; an entry read below its count
// that was never loaded gives an undefined color. Configuration is to be
// written by the user only while no beat is in flight; it is not enforced.
module png_scanline_unfilter_to_rgba_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pngu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         kind,
    input  logic [7:0]                         value,
    input  logic [7:0]                         entry_index,
    input  logic [7:0]                         entry_red,
    input  logic [7:0]                         entry_green,
    input  logic [7:0]                         entry_blue,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic [7:0]                         alpha,
    output logic [11:0]                        column,
    output logic [15:0]                        line_number,
    output logic                               last_of_image,
    output logic                               filter_error
);
    import pngu_pkg::*;

    cfg_t       cfg;
    pix_t       mid;
    tbl_wr_t    tbl_wr;
    logic       mid_valid;
    logic       mid_ready;
    logic       tbl_rd_en;
    logic [7:0] tbl_rd_addr;
    logic       in_fire;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        tbl_wr.pal_we   = in_fire && (kind == KIND_PALETTE);
        tbl_wr.alpha_we = in_fire && (kind == KIND_ALPHA);
        tbl_wr.index    = entry_index;
        tbl_wr.rgb      = {entry_red, entry_green, entry_blue};
        tbl_wr.alpha    = value;
    end

    pngu_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pngu_unfilter u_unfilter (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .mid_valid   (mid_valid),
        .mid_ready   (mid_ready),
        .mid         (mid),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr)
    );

    pngu_color u_color (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .mid_valid     (mid_valid),
        .mid_ready     (mid_ready),
        .mid           (mid),
        .tbl_wr        (tbl_wr),
        .tbl_rd_en     (tbl_rd_en),
        .tbl_rd_addr   (tbl_rd_addr),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .column        (column),
        .line_number   (line_number),
        .last_of_image (last_of_image),
        .filter_error  (filter_error)
    );

endmodule
